FILE: hw/rtl/nmea_gga_position_parser_defines.svh
// Assertion helpers shared by the parser RTL.
`ifndef NMEA_GGA_POSITION_PARSER_DEFINES_SVH
`define NMEA_GGA_POSITION_PARSER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NGP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define NGP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/ngp_pkg.sv
`default_nettype none

package ngp_pkg;

   // Character codes
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_POINT   = 8'h2E;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // Line and number limits
   localparam int          FRAC_DIGITS_DEFAULT = 5;
   localparam logic [4:0]  MAX_FIELDS          = 5'd30;
   localparam logic [2:0]  HEADER_LEN          = 3'd6;
   localparam logic [2:0]  HEADER_POS_MAX      = 3'd7;
   localparam logic [4:0]  FIELD_LAT           = 5'd2;
   localparam logic [4:0]  FIELD_LON           = 5'd4;
   localparam logic [16:0] INT_SAT             = 17'd131071;
   localparam logic [30:0] OUT_SAT             = 31'h7FFF_FFFF;

   // Conversion constants
   localparam logic [23:0] E7        = 24'd10_000_000;
   localparam logic [17:0] RECIP100  = 18'd167_773;      // ceil(2^24 / 100)
   localparam logic [28:0] RECIP15   = 29'd286_331_154;  // ceil(2^32 / 15)

   // Control carried along the conversion pipeline
   typedef struct packed {
      logic conv;    // number of field 2 or 4 to convert
      logic is_lon;  // conversion targets longitude
      logic eol;     // line end
      logic hit;     // line end that yields a result
   } stage_ctl_type;

   // Expected character of the sentence header at a position
   function automatic logic [7:0] hdr_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = 8'h24;  // $
         3'd1:    ch = 8'h47;  // G
         3'd2:    ch = 8'h50;  // P
         3'd3:    ch = 8'h47;  // G
         3'd4:    ch = 8'h47;  // G
         3'd5:    ch = 8'h41;  // A
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Power of ten scaling a fraction to seven digits
   function automatic logic [23:0] pow10(input logic [2:0] exp);
      logic [23:0] p;
      case (exp)
         3'd0:    p = 24'd1;
         3'd1:    p = 24'd10;
         3'd2:    p = 24'd100;
         3'd3:    p = 24'd1000;
         3'd4:    p = 24'd10000;
         3'd5:    p = 24'd100000;
         3'd6:    p = 24'd1000000;
         default: p = 24'd10000000;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nmea_gga_position_parser.sv
// Extracts latitude and longitude from GGA sentences of an NMEA 0183 byte stream. One
// character is accepted per cycle unless a result is held, with no gaps needed between lines.
// Each line end that closes a "$GPGGA" line with a comma-terminated header gives one
// result beat (latitude in bits 30:0, longitude in bits 61:31, both in 1e-7 degree,
// saturated, hemisphere ignored) once the newline has passed through the pipeline: one
// input register, one parse stage, four further conversion stages that turn
// ddmm.mmmmm into degrees with reciprocal multiplies, and the output register. Lines
// that do not match give no beat. While a result waits on rsp_tready the whole
// pipeline holds, so req_tready follows the output register.
`default_nettype none

`include "nmea_gga_position_parser_defines.svh"

module nmea_gga_position_parser #(
   parameter int FRAC_DIGITS = ngp_pkg::FRAC_DIGITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata    // [30:0] latitude_e7, [61:31] longitude_e7, zero
);

   localparam int FRAC_W = $clog2(10 ** FRAC_DIGITS);
   localparam int FX_W   = FRAC_W + 4;
   localparam int FE_W   = FRAC_W + 24;

   // Pipeline advance
   logic adv;

   // Input register
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;

   // Line and number state
   logic [4:0]        field_count_ff, field_count_in;
   logic [2:0]        header_pos_ff, header_pos_in;
   logic              header_ok_ff, header_ok_in;
   logic              line_nonempty_ff, line_nonempty_in;
   logic [16:0]       int_acc_ff, int_acc_in;
   logic [FRAC_W-1:0] frac_acc_ff, frac_acc_in;
   logic [2:0]        frac_cnt_ff, frac_cnt_in;
   logic              point_seen_ff, point_seen_in;
   logic              num_stop_ff, num_stop_in;
   logic [30:0]       lat_ff, lat_in;
   logic [30:0]       lon_ff, lon_in;

   // Conversion pipeline
   ngp_pkg::stage_ctl_type s1_ctl_ff, s1_ctl_in;
   ngp_pkg::stage_ctl_type s2_ctl_ff, s3_ctl_ff, s4_ctl_ff, s5_ctl_ff;
   logic [16:0]       s1_int_ff;
   logic [FRAC_W-1:0] s1_frac_ff;
   logic [2:0]        s1_cnt_ff;
   logic [16:0]       s2_int_ff;
   logic [10:0]       s2_q_ff;
   logic [23:0]       s2_fe7_ff;
   logic [6:0]        s3_rem_ff;
   logic [33:0]       s3_deg_ff;
   logic [23:0]       s3_fe7_ff;
   logic [33:0]       s4_deg_ff;
   logic [29:0]       s4_mins_ff;
   logic [33:0]       s5_deg_ff;
   logic [24:0]       s5_q60_ff;

   // Output register
   logic        rsp_tvalid_ff;
   logic [63:0] rsp_tdata_ff;

   // Parse stage helpers
   logic [7:0]      ch;
   logic            is_digit;
   logic [3:0]      digit;
   logic [20:0]     int_x10;
   logic [FX_W-1:0] frac_x10;

   // Conversion helpers
   logic [34:0]     q_prod;
   logic [FE_W-1:0] fe_prod;
   logic [16:0]     rem_full;
   logic [56:0]     q60_prod;
   logic [34:0]     total;
   logic [30:0]     total_sat;

   // Hold everything while a result waits
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Character decode and digit accumulate
   assign ch       = in_byte_ff;
   assign is_digit = (ch >= ngp_pkg::CHAR_ZERO) && (ch <= ngp_pkg::CHAR_NINE);
   assign digit    = 4'(ch - ngp_pkg::CHAR_ZERO);
   assign int_x10  = 21'(int_acc_ff) * 21'd10 + 21'(digit);
   assign frac_x10 = FX_W'(frac_acc_ff) * FX_W'(10) + FX_W'(digit);

   // Parse one character
   always_comb begin
      field_count_in   = field_count_ff;
      header_pos_in    = header_pos_ff;
      header_ok_in     = header_ok_ff;
      line_nonempty_in = line_nonempty_ff;
      int_acc_in       = int_acc_ff;
      frac_acc_in      = frac_acc_ff;
      frac_cnt_in      = frac_cnt_ff;
      point_seen_in    = point_seen_ff;
      num_stop_in      = num_stop_ff;
      s1_ctl_in        = '0;
      if (in_vld_ff) begin
         if (ch == ngp_pkg::CHAR_NEWLINE) begin
            s1_ctl_in.eol    = 1'b1;
            s1_ctl_in.hit    = line_nonempty_ff && header_ok_ff && (field_count_ff != 5'd0);
            field_count_in   = '0;
            header_pos_in    = '0;
            header_ok_in     = 1'b1;
            line_nonempty_in = 1'b0;
            int_acc_in       = '0;
            frac_acc_in      = '0;
            frac_cnt_in      = '0;
            point_seen_in    = 1'b0;
            num_stop_in      = 1'b0;
         end else begin
            line_nonempty_in = 1'b1;
            if (ch == ngp_pkg::CHAR_COMMA) begin
               // close the open field
               if (field_count_ff == 5'd0 && header_pos_ff != ngp_pkg::HEADER_LEN) begin
                  header_ok_in = 1'b0;
               end
               s1_ctl_in.conv   = (field_count_ff == ngp_pkg::FIELD_LAT) ||
                                  (field_count_ff == ngp_pkg::FIELD_LON);
               s1_ctl_in.is_lon = (field_count_ff == ngp_pkg::FIELD_LON);
               int_acc_in    = '0;
               frac_acc_in   = '0;
               frac_cnt_in   = '0;
               point_seen_in = 1'b0;
               num_stop_in   = 1'b0;
               if (field_count_ff < ngp_pkg::MAX_FIELDS) begin
                  field_count_in = field_count_ff + 5'd1;
               end
            end else begin
               // match the header text
               if (field_count_ff == 5'd0) begin
                  if (header_pos_ff >= ngp_pkg::HEADER_LEN ||
                      ngp_pkg::hdr_char(header_pos_ff) != ch) begin
                     header_ok_in = 1'b0;
                  end
                  if (header_pos_ff < ngp_pkg::HEADER_POS_MAX) begin
                     header_pos_in = header_pos_ff + 3'd1;
                  end
               end
               // accumulate the number
               if (!num_stop_ff) begin
                  if (is_digit) begin
                     if (!point_seen_ff) begin
                        int_acc_in = (int_x10 > 21'(ngp_pkg::INT_SAT)) ?
                                     ngp_pkg::INT_SAT : int_x10[16:0];
                     end else if (frac_cnt_ff < 3'(FRAC_DIGITS)) begin
                        frac_acc_in = frac_x10[FRAC_W-1:0];
                        frac_cnt_in = frac_cnt_ff + 3'd1;
                     end
                  end else if (ch == ngp_pkg::CHAR_POINT && !point_seen_ff) begin
                     point_seen_in = 1'b1;
                  end else begin
                     num_stop_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   // Conversion arithmetic, one multiply per stage path
   assign q_prod   = 35'(s1_int_ff) * 35'(ngp_pkg::RECIP100);
   assign fe_prod  = FE_W'(s1_frac_ff) * FE_W'(ngp_pkg::pow10(3'd7 - s1_cnt_ff));
   assign rem_full = s2_int_ff - 17'(s2_q_ff) * 17'd100;
   assign q60_prod = 57'(s4_mins_ff[29:2]) * 57'(ngp_pkg::RECIP15);
   assign total    = 35'(s5_deg_ff) + 35'(s5_q60_ff);
   assign total_sat = (total > 35'(ngp_pkg::OUT_SAT)) ? ngp_pkg::OUT_SAT : total[30:0];

   // Write converted values, clear them at line end
   always_comb begin
      lat_in = lat_ff;
      lon_in = lon_ff;
      if (s5_ctl_ff.eol) begin
         lat_in = '0;
         lon_in = '0;
      end else if (s5_ctl_ff.conv) begin
         if (s5_ctl_ff.is_lon) begin
            lon_in = total_sat;
         end else begin
            lat_in = total_sat;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff        <= 1'b0;
         field_count_ff   <= '0;
         header_pos_ff    <= '0;
         header_ok_ff     <= 1'b1;
         line_nonempty_ff <= 1'b0;
         int_acc_ff       <= '0;
         frac_acc_ff      <= '0;
         frac_cnt_ff      <= '0;
         point_seen_ff    <= 1'b0;
         num_stop_ff      <= 1'b0;
         lat_ff           <= '0;
         lon_ff           <= '0;
         s1_ctl_ff        <= '0;
         s2_ctl_ff        <= '0;
         s3_ctl_ff        <= '0;
         s4_ctl_ff        <= '0;
         s5_ctl_ff        <= '0;
         rsp_tvalid_ff    <= 1'b0;
      end else if (adv) begin
         in_vld_ff        <= req_tvalid;
         field_count_ff   <= field_count_in;
         header_pos_ff    <= header_pos_in;
         header_ok_ff     <= header_ok_in;
         line_nonempty_ff <= line_nonempty_in;
         int_acc_ff       <= int_acc_in;
         frac_acc_ff      <= frac_acc_in;
         frac_cnt_ff      <= frac_cnt_in;
         point_seen_ff    <= point_seen_in;
         num_stop_ff      <= num_stop_in;
         lat_ff           <= lat_in;
         lon_ff           <= lon_in;
         s1_ctl_ff        <= s1_ctl_in;
         s2_ctl_ff        <= s1_ctl_ff;
         s3_ctl_ff        <= s2_ctl_ff;
         s4_ctl_ff        <= s3_ctl_ff;
         s5_ctl_ff        <= s4_ctl_ff;
         rsp_tvalid_ff    <= s5_ctl_ff.hit;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         in_byte_ff <= req_tdata;
         s1_int_ff  <= int_acc_ff;
         s1_frac_ff <= frac_acc_ff;
         s1_cnt_ff  <= frac_cnt_ff;
         s2_int_ff  <= s1_int_ff;
         s2_q_ff    <= q_prod[34:24];
         s2_fe7_ff  <= fe_prod[23:0];
         s3_rem_ff  <= rem_full[6:0];
         s3_deg_ff  <= 34'(s2_q_ff) * 34'(ngp_pkg::E7);
         s3_fe7_ff  <= s2_fe7_ff;
         s4_deg_ff  <= s3_deg_ff;
         s4_mins_ff <= 30'(s3_rem_ff) * 30'(ngp_pkg::E7) + 30'(s3_fe7_ff);
         s5_deg_ff  <= s4_deg_ff;
         s5_q60_ff  <= q60_prod[56:32];
         if (s5_ctl_ff.hit) begin
            rsp_tdata_ff <= {2'b00, lon_ff, lat_ff};
         end
      end
   end

   // Checks
   `NGP_ASSERT_NEXT(a_hit_loads_rsp, clock, reset, adv && s5_ctl_ff.hit,
      rsp_tvalid_ff, "line hit did not produce a result beat")
   `NGP_ASSERT_NOW(a_ctl_exclusive, clock, reset, s5_ctl_ff.conv || s5_ctl_ff.hit,
      !(s5_ctl_ff.conv && s5_ctl_ff.eol) && (s5_ctl_ff.conv || s5_ctl_ff.eol),
      "conversion and line end overlap in one stage")
   `NGP_ASSERT_NOW(a_field_bound, clock, reset, 1'b1,
      field_count_ff <= ngp_pkg::MAX_FIELDS, "field count past its limit")
   `NGP_ASSERT_NOW(a_empty_line_clean, clock, reset, !line_nonempty_ff,
      field_count_ff == 5'd0 && header_pos_ff == 3'd0 && header_ok_ff,
      "empty line carries field state")

endmodule

`default_nettype wire

FILE: verif/nmea_gga_position_parser_tb.sv
module nmea_gga_position_parser_tb;

   // Parser limits, as ngp_pkg defines them
   localparam int FRAC_KEEP   = 5;
   localparam int FIELD_CAP   = 30;
   localparam int HDR_LEN     = 6;
   localparam int HDR_POS_CAP = 7;
   localparam int FLD_LAT     = 2;
   localparam int FLD_LON     = 4;
   localparam int INT_CAP     = 131071;
   localparam longint unsigned E7_MAX = 64'd2147483647;

   // Character codes
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // Sentence tag, first character in the top byte
   localparam logic [47:0] GGA_TAG = "$GPGGA";

   // Run shape
   localparam int RANDOM_ITEMS = 1650;
   localparam int MAX_WAIT     = 19;
   localparam int PAUSE_EVERY  = 12;
   localparam int TAIL_CYCLES  = 40;
   localparam int STUCK_LIMIT  = 1000;

   typedef struct packed {
      logic [30:0] lat;
      logic [30:0] lon;
   } gga_fix_type;

   // One line of directed stimulus; bit 8 of lead asks for a raw byte before the text
   typedef struct {
      logic [8:0]  lead;
      string       text;
      bit          typed;
      bit          has_fix;
      gga_fix_type fix;
   } dir_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;

   nmea_gga_position_parser #(
      .FRAC_DIGITS(FRAC_KEEP)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Line parser state of the predictor
   logic [4:0]  fld_idx;
   logic [2:0]  hdr_seen;
   bit          hdr_match;
   bit          line_open;
   logic [16:0] int_acc;
   logic [16:0] frac_acc;
   logic [2:0]  frac_cnt;
   bit          got_point;
   bit          num_done;
   logic [30:0] lat_e7;
   logic [30:0] lon_e7;

   gga_fix_type fix_q[$];
   logic [7:0]  line_q[$];
   dir_row_type dir_tab[4];

   bit req_idle = 1'b1;
   bit rsp_idle = 1'b1;
   int errors = 0;
   int bytes_sent = 0;
   int lines_sent = 0;
   int fixes_sent = 0;
   int fixes_checked = 0;
   int sat_hits = 0;
   int stuck_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_number();
      int_acc   = '0;
      frac_acc  = '0;
      frac_cnt  = '0;
      got_point = 1'b0;
      num_done  = 1'b0;
   endfunction

   function automatic void clear_line();
      fld_idx   = '0;
      hdr_seen  = '0;
      hdr_match = 1'b1;
      line_open = 1'b0;
      lat_e7    = '0;
      lon_e7    = '0;
      clear_number();
   endfunction

   // ddmm.mmmmm to 1e-7 degree, saturated
   function automatic logic [30:0] minutes_to_e7(input logic [16:0] ip, input logic [16:0] fp,
                                                 input logic [2:0] nfrac);
      longint unsigned scale;
      longint unsigned total;
      int k;
      scale = 1;
      for (k = nfrac; k < 7; k++)
         scale = scale * 10;
      total = (64'(ip) / 100) * 64'd10000000
            + ((64'(ip) % 100) * 64'd10000000 + 64'(fp) * scale) / 60;
      if (total > E7_MAX) begin
         total = E7_MAX;
         sat_hits++;
      end
      return total[30:0];
   endfunction

   // Advance the line state by one character; flag a fix on a matching line end
   task automatic parse_char(input logic [7:0] ch, output bit hit, output gga_fix_type fix);
      int unsigned grown;
      hit = 1'b0;
      fix = '0;
      if (ch == CH_NL) begin
         hit     = line_open && hdr_match && (fld_idx >= 1);
         fix.lat = lat_e7;
         fix.lon = lon_e7;
         clear_line();
      end else begin
         line_open = 1'b1;
         if (ch == CH_COMMA) begin
            // close the field; a header shorter or longer than the tag fails here
            if (fld_idx == 0 && hdr_seen != HDR_LEN)
               hdr_match = 1'b0;
            if (fld_idx == FLD_LAT)
               lat_e7 = minutes_to_e7(int_acc, frac_acc, frac_cnt);
            else if (fld_idx == FLD_LON)
               lon_e7 = minutes_to_e7(int_acc, frac_acc, frac_cnt);
            clear_number();
            if (fld_idx < FIELD_CAP)
               fld_idx = fld_idx + 1'b1;
         end else begin
            if (fld_idx == 0) begin
               if (hdr_seen >= HDR_LEN || GGA_TAG[47 - 8 * hdr_seen -: 8] != ch)
                  hdr_match = 1'b0;
               if (hdr_seen < HDR_POS_CAP)
                  hdr_seen = hdr_seen + 1'b1;
            end
            // number reading stops for the rest of the field at the first stray character
            if (!num_done) begin
               if (ch >= CH_ZERO && ch <= CH_NINE) begin
                  if (!got_point) begin
                     grown   = 32'(int_acc) * 10 + 32'(ch - CH_ZERO);
                     int_acc = (grown > INT_CAP) ? 17'(INT_CAP) : grown[16:0];
                  end else if (frac_cnt < FRAC_KEEP) begin
                     frac_acc = frac_acc * 10 + 17'(ch - CH_ZERO);
                     frac_cnt = frac_cnt + 1'b1;
                  end
               end else if (ch == CH_POINT && !got_point) begin
                  got_point = 1'b1;
               end else begin
                  num_done = 1'b1;
               end
            end
         end
      end
   endtask

   // Drive one byte, wait for its beat, then record what it should produce
   task automatic send_byte(input logic [7:0] ch, input bit use_typed, input bit typed_has,
                            input gga_fix_type typed_fix);
      int gap;
      bit hit;
      gga_fix_type want;
      gap = req_idle ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      parse_char(ch, hit, want);
      if (use_typed) begin
         if (ch == CH_NL && typed_has) begin
            fix_q.push_back(typed_fix);
            fixes_sent++;
         end
      end else if (hit) begin
         fix_q.push_back(want);
         fixes_sent++;
      end
   endtask

   task automatic put_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         line_q.push_back(s[i]);
   endtask

   task automatic put_digits(input int n);
      repeat (n) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
   endtask

   task automatic put_junk();
      string s;
      s = "-+ xE*.";
      line_q.push_back(s[$urandom_range(0, s.len() - 1)]);
   endtask

   // One coordinate field: mostly plausible, plus overflow, stray characters and empties
   task automatic put_coord();
      case ($urandom_range(0, 11))
         0: ;
         1: begin
            put_digits($urandom_range(6, 9));
            if ($urandom_range(0, 1)) begin
               line_q.push_back(CH_POINT);
               put_digits($urandom_range(0, 8));
            end
         end
         2: begin
            put_junk();
            put_digits($urandom_range(1, 5));
         end
         3: begin
            put_digits($urandom_range(1, 5));
            line_q.push_back(CH_POINT);
            put_digits($urandom_range(0, 3));
            put_junk();
            put_digits($urandom_range(0, 3));
         end
         4: begin
            line_q.push_back(CH_POINT);
            put_digits($urandom_range(1, 8));
         end
         5: put_text($urandom_range(0, 1) ? "99999.99999" : "00000.00000");
         default: begin
            put_digits($urandom_range(3, 5));
            line_q.push_back(CH_POINT);
            put_digits($urandom_range(0, 8));
         end
      endcase
   endtask

   // Sentence with time, latitude, hemisphere, longitude and a tail of fields, possibly cut short
   task automatic put_sentence(input string hdr, input bit mutate);
      int base;
      int cut;
      int extra;
      logic [7:0] b;
      base = line_q.size();
      put_text(hdr);
      if (mutate && hdr.len() > 0) begin
         do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
         line_q[base + $urandom_range(0, hdr.len() - 1)] = b;
      end
      cut = $urandom_range(0, 9);
      line_q.push_back(CH_COMMA);
      put_digits($urandom_range(0, 6));
      line_q.push_back(CH_COMMA);
      put_coord();
      // cut 0 leaves latitude unclosed, cut 1 leaves longitude unclosed
      if (cut != 0) begin
         line_q.push_back(CH_COMMA);
         put_text($urandom_range(0, 1) ? "N" : "S");
         line_q.push_back(CH_COMMA);
         put_coord();
         if (cut != 1) begin
            line_q.push_back(CH_COMMA);
            extra = ($urandom_range(0, 9) == 0) ? $urandom_range(24, 32) : $urandom_range(0, 5);
            repeat (extra) begin
               put_digits($urandom_range(0, 2));
               line_q.push_back(CH_COMMA);
            end
            if ($urandom_range(0, 1))
               put_text("*5A");
         end
      end
      line_q.push_back(CH_NL);
   endtask

   task automatic put_random_line();
      int pick;
      int n;
      logic [7:0] b;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         put_sentence("$GPGGA", $urandom_range(0, 9) == 0);
      end else if (pick < 72) begin
         case ($urandom_range(0, 5))
            0: put_sentence("$GPRMC", 1'b0);
            1: put_sentence("$GPGG", 1'b0);
            2: put_sentence("$GPGGAA", 1'b0);
            3: put_sentence("GPGGA", 1'b0);
            4: put_sentence("$gpgga", 1'b0);
            default: put_sentence("", 1'b0);
         endcase
      end else if (pick < 82) begin
         // noise within one line
         n = $urandom_range(1, 30);
         repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
            line_q.push_back(b);
         end
         line_q.push_back(CH_NL);
      end else if (pick < 88) begin
         line_q.push_back(CH_NL);
      end else if (pick < 94) begin
         // header that the newline ends before any comma
         put_text($urandom_range(0, 1) ? "$GPGGA" : "$GPGGA9.5");
         line_q.push_back(CH_NL);
      end else begin
         // raw bytes, line ends anywhere
         n = $urandom_range(1, 20);
         repeat (n) line_q.push_back(8'($urandom_range(0, 255)));
         line_q.push_back(CH_NL);
      end
   endtask

   task automatic send_line();
      int i;
      for (i = 0; i < line_q.size(); i++)
         send_byte(line_q[i], 1'b0, 1'b0, '0);
      line_q.delete();
      lines_sent++;
   endtask

   // Stimulus: directed lines, then random lines
   initial begin : stimulus
      int r;
      int i;
      clear_line();
      dir_tab[0] = '{9'h000, "$GPGGA,\n", 1'b1, 1'b1, '0};
      dir_tab[1] = '{9'h000, "$GPGGA,,9.,,1\n", 1'b0, 1'b0, '0};
      dir_tab[2] = '{9'h000, "\n", 1'b1, 1'b0, '0};
      dir_tab[3] = '{9'h100, "\377,\n", 1'b1, 1'b0, '0};
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < 4; r++) begin
         if (dir_tab[r].lead[8])
            send_byte(dir_tab[r].lead[7:0], dir_tab[r].typed, dir_tab[r].has_fix, dir_tab[r].fix);
         for (i = 0; i < dir_tab[r].text.len(); i++)
            send_byte(dir_tab[r].text[i], dir_tab[r].typed, dir_tab[r].has_fix, dir_tab[r].fix);
         lines_sent++;
      end

      while (bytes_sent < RANDOM_ITEMS) begin
         req_idle = ($urandom_range(0, 3) != 0);
         put_random_line();
         send_line();
         // hold off until the block has delivered everything owed
         if (lines_sent % PAUSE_EVERY == 0) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (fix_q.size() != 0);
         end
      end
      req_tvalid <= 1'b0;

      while (fix_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d bytes in %0d lines; checked %0d position fixes, %0d conversions saturated",
               bytes_sent, lines_sent, fixes_checked, sat_hits);
      if (errors == 0 && fix_q.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Result side: stall at random, then compare each beat with the oldest fix
   initial begin : result_side
      int stall;
      gga_fix_type want;
      logic [30:0] got_lat;
      logic [30:0] got_lon;
      logic [1:0] got_pad;
      wait (!reset);
      forever begin
         stall = rsp_idle ? $urandom_range(0, MAX_WAIT) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            do @(posedge clock); while (!rsp_tvalid);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         // [30:0] latitude_e7, [61:31] longitude_e7, [63:62] zero
         got_lat = rsp_tdata[30:0];
         got_lon = rsp_tdata[61:31];
         got_pad = rsp_tdata[63:62];
         if (fix_q.size() == 0) begin
            $display("%0t unexpected beat: expected none, actual lat %0d lon %0d",
                     $time, got_lat, got_lon);
            errors++;
         end else begin
            want = fix_q.pop_front();
            fixes_checked++;
            if (got_lat !== want.lat) begin
               $display("%0t latitude mismatch: expected %0d, actual %0d",
                        $time, want.lat, got_lat);
               errors++;
            end
            if (got_lon !== want.lon) begin
               $display("%0t longitude mismatch: expected %0d, actual %0d",
                        $time, want.lon, got_lon);
               errors++;
            end
            if (got_pad !== 2'b00) begin
               $display("%0t padding mismatch: expected 0, actual %0b", $time, got_pad);
               errors++;
            end
         end
         if ($urandom_range(0, 7) == 0)
            rsp_idle = !rsp_idle;
      end
   end

   // Watchdog: end the run when no beat moves on either side for too long
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stuck_cycles <= 0;
         else
            stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t timeout: no beat for %0d cycles, %0d fixes outstanding",
                     $time, stuck_cycles, fix_q.size());
            $display("Regression FAIL");
            $finish;
         end
      end
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/ngp_pkg.sv
hw/rtl/nmea_gga_position_parser.sv
verif/nmea_gga_position_parser_tb.sv
